// File: sv/clipped_span_write_generator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the clipped span write generator
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_SPAN_WRITE_GENERATOR_ASSERT_SVH
`define CLIPPED_SPAN_WRITE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define CSWG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSWG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cswg_pkg.sv
// ---------------------------------------------------------------------------
// cswg_pkg
// Types and constants of the clipped span write generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cswg_pkg;

  localparam int MAX_SIDE       = 64;
  localparam int COLOR_BITS     = 24;
  localparam int COORD_BITS     = $clog2(MAX_SIDE);
  localparam int ADDR_BITS      = 2 * COORD_BITS;
  localparam int SIDE_BITS      = 7;
  localparam int REM_BITS       = COORD_BITS + 1;
  localparam int POS_BITS       = 16;
  localparam int SUM_BITS       = POS_BITS + 1;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_HLINE = 2'd1;
  localparam logic [1:0] OP_VLINE = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [SIDE_BITS-1:0] FRAME_WIDTH_RESET  = 7'd32;
  localparam logic [SIDE_BITS-1:0] FRAME_HEIGHT_RESET = 7'd8;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [POS_BITS-1:0]   x_pos;
    logic signed [POS_BITS-1:0]   y_pos;
    logic signed [POS_BITS-1:0]   span_length;
    logic [COLOR_BITS-1:0]        pixel_color;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  write_address;
    logic [COLOR_BITS-1:0] write_color;
    logic                  last_write;
  } wr_t;

endpackage

// File: sv/clipped_span_write_generator.sv
// ---------------------------------------------------------------------------
// clipped_span_write_generator
// Turns a pixel, horizontal or vertical span command into clipped
// frame-buffer writes, one beat per surviving pixel, last one marked.
//
//   channel  dir  handshake          beat
//   cmd      in   cmd_valid/stall    cmd_t: op, x, y, length, color
//   wr       out  wr_valid/stall     wr_t: address, color, last
//   cfg      in   cfg_valid/ready    index, 7-bit frame side
//
// A command passes span sum and clip, then a shift-add row*width multiply
// on the shared address adder, then steps the address once per write on
// that same adder; a rejected command goes back to idle after clip.
// cmd_stall is high from acceptance until the last write is registered or the command is rejected.
// wr_stall holds the output register and, in the emit state, the sequencer with it.
// rst is synchronous; frame sides return to 32 x 8.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_span_write_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  output logic                                   cmd_stall,
  input  cswg_pkg::cmd_t                         cmd,
  output logic                                   wr_valid,
  input  logic                                   wr_stall,
  output cswg_pkg::wr_t                          wr,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cswg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cswg_pkg::SIDE_BITS-1:0]         cfg_data
);

  localparam int MUL_CNT_BITS = $clog2(cswg_pkg::COORD_BITS);
  localparam int SB = cswg_pkg::SIDE_BITS;
  localparam int AB = cswg_pkg::ADDR_BITS;
  localparam int CB = cswg_pkg::COORD_BITS;
  localparam int UB = cswg_pkg::SUM_BITS;
  localparam int RB = cswg_pkg::REM_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_CLIP = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                  state;
  cswg_pkg::cmd_t          cmd_q;
  cswg_pkg::wr_t           wr_q;
  logic                    wr_q_valid;
  logic [SB-1:0]           frame_width;
  logic [SB-1:0]           frame_height;
  logic signed [UB-1:0]    span_end;
  logic                    fixed_ok;
  logic                    op_ok;
  logic [AB-1:0]           current_address;
  logic [RB-1:0]           writes_remaining;
  logic [SB-1:0]           address_step;
  logic [AB-1:0]           mul_operand;
  logic [CB-1:0]           row_shift;
  logic [MUL_CNT_BITS-1:0] mul_cnt;

  logic [SB-1:0]           side_w;
  logic [SB-1:0]           side_h;
  logic                    is_v;
  logic signed [cswg_pkg::POS_BITS-1:0] pos;
  logic signed [cswg_pkg::POS_BITS-1:0] fixed;
  logic signed [cswg_pkg::POS_BITS-1:0] len;
  logic signed [UB-1:0]    pos_s;
  logic signed [UB-1:0]    fixed_s;
  logic signed [UB-1:0]    side_s;
  logic signed [UB-1:0]    fside_s;
  logic signed [UB-1:0]    lo;
  logic signed [UB-1:0]    hi;
  logic signed [UB:0]      cnt;
  logic                    clip_ok;
  logic [CB-1:0]           start;
  logic [AB-1:0]           addend;
  logic [AB-1:0]           sum;
  logic                    emit_load;

  assign side_w = (frame_width > SB'(cswg_pkg::MAX_SIDE)) ? SB'(cswg_pkg::MAX_SIDE)
                                                          : frame_width;
  assign side_h = (frame_height > SB'(cswg_pkg::MAX_SIDE)) ? SB'(cswg_pkg::MAX_SIDE)
                                                           : frame_height;

  // a pixel is a horizontal span of length one
  assign is_v    = (cmd_q.operation == cswg_pkg::OP_VLINE);
  assign pos     = is_v ? cmd_q.y_pos : cmd_q.x_pos;
  assign fixed   = is_v ? cmd_q.x_pos : cmd_q.y_pos;
  assign len     = (cmd_q.operation == cswg_pkg::OP_PIXEL) ? 16'sd1 : cmd_q.span_length;
  assign pos_s   = {pos[cswg_pkg::POS_BITS-1], pos};
  assign fixed_s = {fixed[cswg_pkg::POS_BITS-1], fixed};
  assign side_s  = $signed({{(UB-SB){1'b0}}, (is_v ? side_h : side_w)});
  assign fside_s = $signed({{(UB-SB){1'b0}}, (is_v ? side_w : side_h)});

  always_comb begin
    if (len[cswg_pkg::POS_BITS-1]) begin
      lo = span_end;
      hi = pos_s;
    end else begin
      lo = pos_s[UB-1] ? '0 : pos_s;
      hi = (span_end > side_s) ? side_s : span_end;
    end
  end

  assign cnt     = {hi[UB-1], hi} - {lo[UB-1], lo};
  assign clip_ok = op_ok && fixed_ok && !span_end[UB-1] && !(pos_s >= side_s) &&
                   (cnt > 0);
  assign start   = lo[CB-1:0];

  // shared address adder: shift-add multiply, then address stepping
  assign addend = (state == ST_MUL) ? (row_shift[0] ? mul_operand : '0)
                                    : {{(AB-SB){1'b0}}, address_step};
  assign sum    = current_address + addend;

  assign emit_load = (state == ST_EMIT) && (!wr_valid || !wr_stall);

  assign cmd_stall = (state != ST_IDLE);
  assign wr_valid  = wr_q_valid;
  assign wr        = wr_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cswg_pkg::FRAME_WIDTH_RESET;
      frame_height <= cswg_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cswg_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        cswg_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      wr_q_valid       <= 1'b0;
      current_address  <= '0;
      writes_remaining <= '0;
      address_step     <= '0;
    end else begin
      if (emit_load) begin
        wr_q_valid <= 1'b1;
      end else if (!wr_stall) begin
        wr_q_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          span_end <= pos_s + {len[cswg_pkg::POS_BITS-1], len};
          fixed_ok <= !fixed_s[UB-1] && (fixed_s < fside_s);
          op_ok    <= (cmd_q.operation == cswg_pkg::OP_PIXEL) ||
                      (cmd_q.operation == cswg_pkg::OP_HLINE) ||
                      (cmd_q.operation == cswg_pkg::OP_VLINE);
          state    <= ST_CLIP;
        end
        ST_CLIP: begin
          if (clip_ok) begin
            writes_remaining <= cnt[RB-1:0];
            row_shift        <= is_v ? start : cmd_q.y_pos[CB-1:0];
            current_address  <= {{(AB-CB){1'b0}}, (is_v ? cmd_q.x_pos[CB-1:0] : start)};
            mul_operand      <= {{(AB-SB){1'b0}}, side_w};
            address_step     <= is_v ? side_w : SB'(1);
            mul_cnt          <= '0;
            state            <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          current_address <= sum;
          row_shift       <= row_shift >> 1;
          mul_operand     <= mul_operand << 1;
          mul_cnt         <= mul_cnt + MUL_CNT_BITS'(1);
          if (mul_cnt == MUL_CNT_BITS'(CB - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            wr_q.write_address <= current_address;
            wr_q.write_color   <= cmd_q.pixel_color;
            wr_q.last_write    <= (writes_remaining == RB'(1));
            current_address    <= sum;
            writes_remaining   <= writes_remaining - RB'(1);
            if (writes_remaining == RB'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "clipped_span_write_generator_assert.svh"

  `CSWG_ASSERT_NEXT(a_stall_hold, wr_valid && wr_stall, wr_valid && $stable(wr), "beat moved")
  `CSWG_ASSERT_NOW(a_emit_pending, state == ST_EMIT, writes_remaining != '0, "emit state with no writes left")
  `CSWG_ASSERT_NOW(a_mul_pending, state == ST_MUL, writes_remaining != '0, "multiply started for an empty span")
  `CSWG_ASSERT_NOW(a_more_follow, wr_valid && !wr.last_write, state == ST_EMIT, "non-last beat with sequencer not emitting")

endmodule
